[rtl/core/dbst_pkg.sv]
// Shared types, codes and character-class helpers for the byte stream tokenizer.
package dbst_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LINE_BITS   = 20;
	localparam int COLUMN_BITS = 16;
	localparam int CNT_BITS    = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef enum logic [4:0] {
		KIND_END   = 5'd0,
		KIND_INT   = 5'd1,
		KIND_FLOAT = 5'd2,
		KIND_IDENT = 5'd3,
		KIND_ERROR = 5'd4,
		KIND_DIAG  = 5'd28
	} kind_code_t;

	localparam logic [4:0] KIND_ARROW  = 5'd12;
	localparam logic [4:0] KIND_FATARR = 5'd13;
	localparam logic [4:0] KIND_STARAMP = 5'd14;
	localparam logic [4:0] KIND_DOTDOT = 5'd15;

	localparam logic [2:0] DIAG_NONE     = 3'd0;
	localparam logic [2:0] DIAG_BAD_CHAR = 3'd1;
	localparam logic [2:0] DIAG_UNCLOSED = 3'd2;
	localparam logic [2:0] DIAG_BAD_NUM  = 3'd3;
	localparam logic [2:0] DIAG_EMPTY_SIGIL = 3'd4;

	typedef enum logic [4:0] {
		M_IDLE, M_SKIP, M_LCOM, M_BOPEN, M_BCOM, M_BCLOSE, M_ID, M_KEBAB,
		M_DOTTED, M_JUNK, M_PFX, M_HEX, M_BIN, M_DEC, M_DOT, M_FRAC,
		M_EXPE, M_EXPSIGN, M_EXPDIG, M_TAIL
	} lex_mode_t;

	// One unit of work for the back end: a byte with its two lookahead bytes,
	// or the end-of-source finish step.
	typedef struct packed {
		logic       fin;
		logic [7:0] c;
		logic [7:0] c1;
		logic [7:0] c2;
	} step_t;

	typedef struct packed {
		logic [4:0]             kind;
		logic [2:0]             diag;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [OFFSET_BITS-1:0] off;
		logic [CNT_BITS-1:0]    span;
		logic [CNT_BITS-1:0]    text;
		logic [63:0]            value;
		logic [CNT_BITS-1:0]    cps;
		logic                   last;
	} tok_rec_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_alpha(c) || is_digit(c);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	function automatic logic [4:0] punct1(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			"[": k = 5'd16;
			"]": k = 5'd17;
			"(": k = 5'd18;
			")": k = 5'd19;
			"<": k = 5'd20;
			">": k = 5'd21;
			",": k = 5'd22;
			";": k = 5'd23;
			":": k = 5'd24;
			".": k = 5'd25;
			"*": k = 5'd26;
			"-": k = 5'd27;
			default: k = 5'd0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] sigil_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			"$": k = 5'd5;
			"@": k = 5'd6;
			"#": k = 5'd7;
			"^": k = 5'd8;
			"!": k = 5'd9;
			"?": k = 5'd10;
			"~": k = 5'd11;
			default: k = 5'd0;
		endcase
		return k;
	endfunction

endpackage

[rtl/core/dbst_front.sv]
// Front end: lookahead window that turns input bytes into work steps.
module dbst_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_end,
	input  logic               q_full,
	output logic               push,
	output dbst_pkg::step_t    push_step
);

	logic       flush_q;
	logic [1:0] cnt_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	logic       acc;

	assign in_ready = !flush_q && !q_full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		push      = 1'b0;
		push_step = '0;
		if (flush_q && !q_full) begin
			push = 1'b1;
			case (cnt_q)
				2'd2: push_step = '{fin: 1'b0, c: b0_q, c1: b1_q, c2: 8'd0};
				2'd1: push_step = '{fin: 1'b0, c: b0_q, c1: 8'd0, c2: 8'd0};
				default: push_step = '{fin: 1'b1, c: 8'd0, c1: 8'd0, c2: 8'd0};
			endcase
		end else if (acc && !in_end && cnt_q == 2'd2) begin
			push      = 1'b1;
			push_step = '{fin: 1'b0, c: b0_q, c1: b1_q, c2: in_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= 1'b0;
			cnt_q   <= 2'd0;
		end else if (flush_q) begin
			if (!q_full) begin
				if (cnt_q == 2'd0)
					flush_q <= 1'b0;
				else
					cnt_q <= cnt_q - 2'd1;
			end
		end else if (acc) begin
			if (in_end)
				flush_q <= 1'b1;
			else if (cnt_q != 2'd2)
				cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (flush_q && !q_full && cnt_q == 2'd2) begin
			b0_q <= b1_q;
		end else if (acc && !in_end) begin
			case (cnt_q)
				2'd0: b0_q <= in_byte;
				2'd1: b1_q <= in_byte;
				default: begin
					b0_q <= b1_q;
					b1_q <= in_byte;
				end
			endcase
		end
	end

endmodule

[rtl/core/dbst_fifo.sv]
// Short step queue between the front end and the back end.
module dbst_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dbst_pkg::step_t din,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output dbst_pkg::step_t dout
);

	dbst_pkg::step_t                 mem [dbst_pkg::QUEUE_DEPTH];
	logic [dbst_pkg::QPTR_BITS-1:0]  wr_q;
	logic [dbst_pkg::QPTR_BITS-1:0]  rd_q;
	logic [dbst_pkg::QPTR_BITS:0]    count_q;

	assign full  = (count_q == (dbst_pkg::QPTR_BITS+1)'(dbst_pkg::QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign dout  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/core/dbst_back.sv]
// Back end: lexer state machine, position counters and the output register.
module dbst_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  dbst_pkg::step_t    q_step,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output dbst_pkg::tok_rec_t out_rec
);

	localparam int LB = dbst_pkg::LINE_BITS;
	localparam int CB = dbst_pkg::COLUMN_BITS;
	localparam int OB = dbst_pkg::OFFSET_BITS;
	localparam int NB = dbst_pkg::CNT_BITS;

	dbst_pkg::lex_mode_t mode_q, mode_d;
	logic [LB-1:0] line_q, line_d, tsl_q, tsl_d;
	logic [CB-1:0] col_q, col_d, tsc_q, tsc_d;
	logic [OB-1:0] off_q, off_d, tso_q, tso_d;
	logic [NB-1:0] span_q, span_d, text_q, text_d, cps_q, cps_d;
	logic [63:0]   val_q, val_d;
	logic [4:0]    tkind_q, tkind_d;
	logic          digits_q, digits_d, r16_q, r16_d, bad_q, bad_d, flt_q, flt_d;

	logic               out_valid_q;
	dbst_pkg::tok_rec_t rec_q;
	dbst_pkg::tok_rec_t rec;
	logic               step, emit, want_num, end_rec, more;
	logic [7:0]         c, c1, c2;
	logic [4:0]         k2, kp, ks;
	logic [3:0]         dig;

	assign out_valid = out_valid_q;
	assign out_rec   = rec_q;
	assign step      = q_valid && (!out_valid_q || out_ready);
	assign c         = q_step.c;
	assign c1        = q_step.c1;
	assign c2        = q_step.c2;

	always_comb begin
		mode_d = mode_q; line_d = line_q; col_d = col_q; off_d = off_q;
		tsl_d = tsl_q; tsc_d = tsc_q; tso_d = tso_q;
		span_d = span_q; text_d = text_q; cps_d = cps_q; val_d = val_q;
		tkind_d = tkind_q; digits_d = digits_q; r16_d = r16_q;
		bad_d = bad_q; flt_d = flt_q;
		emit = 1'b0; want_num = 1'b0; end_rec = 1'b0; pop = 1'b0; more = 1'b0;
		rec = '0;
		k2 = 5'd0;
		kp = dbst_pkg::punct1(c);
		ks = dbst_pkg::sigil_kind(c);
		dig = dbst_pkg::is_digit(c) ? c[3:0] : 4'((c | 8'h20) - "a" + 8'd10);

		if (step && q_step.fin) begin
			if (mode_q == dbst_pkg::M_BOPEN || mode_q == dbst_pkg::M_BCOM) begin
				// Unclosed block comment: report at the opener, finish next pass.
				emit = 1'b1;
				rec.kind = dbst_pkg::KIND_DIAG;
				rec.diag = dbst_pkg::DIAG_UNCLOSED;
				rec.span = NB'(2);
				rec.text = NB'(2);
				mode_d = dbst_pkg::M_IDLE;
			end else begin
				pop = 1'b1;
				emit = 1'b1;
				end_rec = 1'b1;
				rec.kind = dbst_pkg::KIND_END;
				rec.line = line_q;
				rec.col = col_q;
				rec.off = off_q;
				rec.last = 1'b1;
				mode_d = dbst_pkg::M_IDLE;
				line_d = LB'(1); col_d = CB'(1); off_d = '0;
				tsl_d = LB'(1); tsc_d = CB'(1); tso_d = '0;
				span_d = '0; text_d = '0; cps_d = '0; val_d = '0;
				tkind_d = '0; digits_d = 1'b0; r16_d = 1'b0;
				bad_d = 1'b0; flt_d = 1'b0;
			end
		end else if (step) begin
			pop = 1'b1;
			off_d = (off_q == '1) ? off_q : off_q + 1'b1;
			if (c == 8'h0A) begin
				line_d = (line_q == '1) ? line_q : line_q + 1'b1;
				col_d  = CB'(1);
			end else begin
				col_d = (col_q == '1) ? col_q : col_q + 1'b1;
			end
			if (mode_q >= dbst_pkg::M_ID)
				span_d = (span_q == '1) ? span_q : span_q + 1'b1;

			case (mode_q)
				dbst_pkg::M_IDLE: begin
					if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
						mode_d = dbst_pkg::M_IDLE;
					end else if (c == "/" && c1 == "/") begin
						mode_d = dbst_pkg::M_LCOM;
					end else begin
						tsl_d = line_q; tsc_d = col_q; tso_d = off_q;
						span_d = NB'(1); text_d = '0; val_d = '0;
						digits_d = 1'b0; cps_d = '0; bad_d = 1'b0; flt_d = 1'b0;
						if (c == "-" && c1 == ">") k2 = KIND_ARROW_C();
						else if (c == "=" && c1 == ">") k2 = dbst_pkg::KIND_FATARR;
						else if (c == "*" && c1 == "&") k2 = dbst_pkg::KIND_STARAMP;
						else if (c == "." && c1 == ".") k2 = dbst_pkg::KIND_DOTDOT;
						if (c == "/" && c1 == "*") begin
							mode_d = dbst_pkg::M_BOPEN;
						end else if (k2 != 5'd0) begin
							emit = 1'b1;
							rec.kind = k2;
							rec.span = NB'(2);
							rec.text = NB'(2);
							mode_d = dbst_pkg::M_SKIP;
						end else if (kp != 5'd0) begin
							emit = 1'b1;
							rec.kind = kp;
							rec.span = NB'(1);
							rec.text = NB'(1);
						end else if (ks != 5'd0) begin
							tkind_d = ks;
							if (!dbst_pkg::is_alpha(c1)) begin
								emit = 1'b1;
								rec.kind = dbst_pkg::KIND_ERROR;
								rec.diag = dbst_pkg::DIAG_EMPTY_SIGIL;
								rec.span = NB'(1);
							end else if (c == "@") begin
								mode_d = dbst_pkg::M_DOTTED;
							end else if (c == "!" || c == "~") begin
								mode_d = dbst_pkg::M_KEBAB;
							end else begin
								mode_d = dbst_pkg::M_ID;
							end
						end else if (dbst_pkg::is_digit(c)) begin
							if (c == "0" && (c1 == "x" || c1 == "X")) begin
								r16_d = 1'b1;
								mode_d = dbst_pkg::M_PFX;
							end else if (c == "0" && (c1 == "b" || c1 == "B")) begin
								r16_d = 1'b0;
								mode_d = dbst_pkg::M_PFX;
							end else begin
								val_d = 64'(c[3:0]);
								dec_step();
							end
						end else if (dbst_pkg::is_alpha(c)) begin
							tkind_d = dbst_pkg::KIND_IDENT;
							text_d = NB'(1);
							mode_d = dbst_pkg::M_ID;
							more = dbst_pkg::is_alnum(c1);
							if (!more) begin
								emit = 1'b1;
								rec.kind = dbst_pkg::KIND_IDENT;
								rec.span = span_d;
								rec.text = text_d;
								mode_d = dbst_pkg::M_IDLE;
							end
						end else if (c[7]) begin
							cps_d = (c[7:6] != 2'b10) ? NB'(1) : '0;
							if (c1[7]) begin
								mode_d = dbst_pkg::M_JUNK;
							end else begin
								emit = 1'b1;
								rec.kind = dbst_pkg::KIND_DIAG;
								rec.diag = dbst_pkg::DIAG_BAD_CHAR;
								rec.span = NB'(1);
								rec.text = NB'(1);
								rec.cps = cps_d;
							end
						end else begin
							emit = 1'b1;
							rec.kind = dbst_pkg::KIND_DIAG;
							rec.diag = dbst_pkg::DIAG_BAD_CHAR;
							rec.span = NB'(1);
							rec.text = NB'(1);
						end
					end
				end
				dbst_pkg::M_SKIP, dbst_pkg::M_BCLOSE: mode_d = dbst_pkg::M_IDLE;
				dbst_pkg::M_LCOM: if (c == 8'h0A) mode_d = dbst_pkg::M_IDLE;
				dbst_pkg::M_BOPEN: mode_d = dbst_pkg::M_BCOM;
				dbst_pkg::M_BCOM: if (c == "*" && c1 == "/") mode_d = dbst_pkg::M_BCLOSE;
				dbst_pkg::M_ID, dbst_pkg::M_KEBAB, dbst_pkg::M_DOTTED: begin
					text_d = (text_q == '1) ? text_q : text_q + 1'b1;
					more = dbst_pkg::is_alnum(c1)
						|| (mode_q == dbst_pkg::M_KEBAB && c1 == "-" && dbst_pkg::is_alnum(c2))
						|| (mode_q == dbst_pkg::M_DOTTED && c1 == "." && dbst_pkg::is_alpha(c2));
					if (!more) begin
						emit = 1'b1;
						rec.kind = tkind_q;
						rec.span = span_d;
						rec.text = text_d;
						mode_d = dbst_pkg::M_IDLE;
					end
				end
				dbst_pkg::M_JUNK: begin
					if (c[7:6] != 2'b10)
						cps_d = (cps_q == '1) ? cps_q : cps_q + 1'b1;
					if (!c1[7]) begin
						emit = 1'b1;
						rec.kind = dbst_pkg::KIND_DIAG;
						rec.diag = dbst_pkg::DIAG_BAD_CHAR;
						rec.span = span_d;
						rec.text = span_d;
						rec.cps = cps_d;
						mode_d = dbst_pkg::M_IDLE;
					end
				end
				dbst_pkg::M_PFX: begin
					mode_d = r16_q ? dbst_pkg::M_HEX : dbst_pkg::M_BIN;
					radix_step();
				end
				dbst_pkg::M_HEX, dbst_pkg::M_BIN: begin
					if (c != "_") begin
						val_d = r16_q ? {val_q[59:0], dig} : {val_q[62:0], dig[0]};
						digits_d = 1'b1;
					end
					radix_step();
				end
				dbst_pkg::M_DEC: begin
					if (dbst_pkg::is_digit(c))
						val_d = {val_q[60:0], 3'b000} + {val_q[62:0], 1'b0} + 64'(c[3:0]);
					dec_step();
				end
				dbst_pkg::M_DOT: begin
					if (dbst_pkg::is_digit(c1)) begin
						flt_d = 1'b1;
						mode_d = dbst_pkg::M_FRAC;
					end else begin
						bad_d = 1'b1;
						exp_step();
					end
				end
				dbst_pkg::M_FRAC: if (!(dbst_pkg::is_digit(c1) || c1 == "_")) exp_step();
				dbst_pkg::M_EXPE: begin
					if (dbst_pkg::is_digit(c1)
						|| ((c1 == "+" || c1 == "-") && dbst_pkg::is_digit(c2))) begin
						flt_d = 1'b1;
						mode_d = (c1 == "+" || c1 == "-") ? dbst_pkg::M_EXPSIGN
							: dbst_pkg::M_EXPDIG;
					end else begin
						bad_d = 1'b1;
						if (dbst_pkg::is_alnum(c1)) mode_d = dbst_pkg::M_TAIL;
						else want_num = 1'b1;
					end
				end
				dbst_pkg::M_EXPSIGN: mode_d = dbst_pkg::M_EXPDIG;
				dbst_pkg::M_EXPDIG: if (!dbst_pkg::is_digit(c1)) tail_step();
				dbst_pkg::M_TAIL: if (!dbst_pkg::is_alnum(c1)) want_num = 1'b1;
				default: mode_d = dbst_pkg::M_IDLE;
			endcase

			if (want_num) begin
				emit = 1'b1;
				mode_d = dbst_pkg::M_IDLE;
				rec.span = span_d;
				rec.text = span_d;
				if (bad_d) begin
					rec.kind = dbst_pkg::KIND_ERROR;
					rec.diag = dbst_pkg::DIAG_BAD_NUM;
				end else if (flt_d) begin
					rec.kind = dbst_pkg::KIND_FLOAT;
				end else begin
					rec.kind = dbst_pkg::KIND_INT;
					rec.value = val_d;
				end
			end
		end

		if (!end_rec) begin
			rec.line = tsl_d;
			rec.col = tsc_d;
			rec.off = tso_d;
		end
	end

	function automatic logic [4:0] KIND_ARROW_C();
		return dbst_pkg::KIND_ARROW;
	endfunction

	// Number suffix checks. They only touch mode_d, bad_d and want_num.
	task automatic tail_step();
		if (dbst_pkg::is_alpha(c1)) begin
			bad_d = 1'b1;
			mode_d = dbst_pkg::M_TAIL;
		end else begin
			want_num = 1'b1;
		end
	endtask

	task automatic exp_step();
		if (c1 == "e" || c1 == "E") mode_d = dbst_pkg::M_EXPE;
		else tail_step();
	endtask

	task automatic dec_step();
		if (dbst_pkg::is_digit(c1) || c1 == "_") mode_d = dbst_pkg::M_DEC;
		else if (c1 == "." && c2 != ".") mode_d = dbst_pkg::M_DOT;
		else exp_step();
	endtask

	task automatic radix_step();
		logic ok;
		ok = r16_q ? dbst_pkg::is_hex(c1) : (c1 == "0" || c1 == "1");
		if (!(ok || c1 == "_")) begin
			if (!digits_d) bad_d = 1'b1;
			tail_step();
		end
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dbst_pkg::M_IDLE;
			line_q <= LB'(1); col_q <= CB'(1); off_q <= '0;
			tsl_q <= LB'(1); tsc_q <= CB'(1); tso_q <= '0;
			span_q <= '0; text_q <= '0; cps_q <= '0; val_q <= '0;
			tkind_q <= '0; digits_q <= 1'b0; r16_q <= 1'b0;
			bad_q <= 1'b0; flt_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			line_q <= line_d; col_q <= col_d; off_q <= off_d;
			tsl_q <= tsl_d; tsc_q <= tsc_d; tso_q <= tso_d;
			span_q <= span_d; text_q <= text_d; cps_q <= cps_d; val_q <= val_d;
			tkind_q <= tkind_d; digits_q <= digits_d; r16_q <= r16_d;
			bad_q <= bad_d; flt_q <= flt_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			rec_q <= rec;
	end

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rec_q.last |-> rec_q.kind == dbst_pkg::KIND_END)
		else $error("end flag on a record that is not the end token");

	a_diag_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rec_q.diag != dbst_pkg::DIAG_NONE
		|-> rec_q.kind == dbst_pkg::KIND_ERROR || rec_q.kind == dbst_pkg::KIND_DIAG)
		else $error("diagnostic code on a plain token");

	a_finish_resets: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_step.fin |=> mode_q == dbst_pkg::M_IDLE && off_q == '0 && line_q == LB'(1))
		else $error("state not back to start after the end token");

endmodule

[rtl/core/dsl_byte_stream_tokenizer.sv]
// Top level of the byte stream tokenizer: front end, step queue and back end.
//
//  channel | dir | handshake         | payload
//  s       | in  | s_tvalid/s_tready | s_tdata[7:0] source_byte, s_tlast end_of_source
//  m       | out | m_tvalid/m_tready | m_tdata token position and values,
//          |     |                   | m_tuser kind and diag code, m_tlast end token
//
// One source byte is taken per cycle while s_tready is high; it drops when the step
// queue is full. A byte reaches the back end once two more bytes have arrived behind
// it, so records lag the input by two bytes plus the queue and the output register.
// The end-of-source request makes the front end drain its held bytes (up to two)
// and then the finish step, during which s_tready is low; an unclosed block comment
// adds its own record before the end token. Each back-end step yields at most one
// record, so the back end stalls only while the output register is full and not
// taken. Reset clears the control state at once; there is no clearing pass.
module dsl_byte_stream_tokenizer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] source_byte
	input  logic         s_tlast,  // end_of_source
	output logic         m_tvalid,
	input  logic         m_tready,
	// [19:0] start_line, [35:20] start_column, [59:36] start_offset,
	// [75:60] span_length, [91:76] text_length, [155:92] int_value,
	// [171:156] codepoint_count, [175:172] zero
	output logic [175:0] m_tdata,
	output logic [7:0]   m_tuser,  // [4:0] token_kind, [7:5] diag_code
	output logic         m_tlast   // last
);

	logic               q_full, push, pop, q_valid;
	dbst_pkg::step_t    push_step, q_step;
	dbst_pkg::tok_rec_t rec;

	dbst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_end    (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_step (push_step)
	);

	// The queue lets the front end keep taking bytes while a record waits.
	dbst_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_step),
		.full   (q_full),
		.pop    (pop),
		.valid  (q_valid),
		.dout   (q_step)
	);

	dbst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_step    (q_step),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (rec)
	);

	assign m_tdata = {4'b0000, rec.cps, rec.value, rec.text, rec.span,
		rec.off, rec.col, rec.line};
	assign m_tuser = {rec.diag, rec.kind};
	assign m_tlast = rec.last;

endmodule

[test/tb_dsl_byte_stream_tokenizer.sv]
// Self-checking testbench for the byte stream tokenizer: directed and random source text.
module tb_dsl_byte_stream_tokenizer;
	import dbst_pkg::*;

	// Kind codes that the package does not name.
	localparam logic [4:0] SIG_DOLLAR = 5'd5;
	localparam logic [4:0] SIG_AT     = 5'd6;
	localparam logic [4:0] SIG_HASH   = 5'd7;
	localparam logic [4:0] SIG_CARET  = 5'd8;
	localparam logic [4:0] SIG_BANG   = 5'd9;
	localparam logic [4:0] SIG_QUEST  = 5'd10;
	localparam logic [4:0] SIG_TILDE  = 5'd11;
	localparam logic [4:0] P_LBRACK   = 5'd16;
	localparam logic [4:0] P_RBRACK   = 5'd17;
	localparam logic [4:0] P_LPAREN   = 5'd18;
	localparam logic [4:0] P_RPAREN   = 5'd19;
	localparam logic [4:0] P_LESS     = 5'd20;
	localparam logic [4:0] P_GREATER  = 5'd21;
	localparam logic [4:0] P_COMMA    = 5'd22;
	localparam logic [4:0] P_SEMI     = 5'd23;
	localparam logic [4:0] P_COLON    = 5'd24;
	localparam logic [4:0] P_DOT      = 5'd25;
	localparam logic [4:0] P_STAR     = 5'd26;
	localparam logic [4:0] P_MINUS    = 5'd27;
	localparam logic [4:0] NO_KIND    = 5'd0;

	// One source request, with an optional kind and diag code typed in for the
	// first record that it releases.
	typedef struct packed {
		logic [7:0] b;
		logic       eos;
		logic       typed;
		logic [4:0] kind;
		logic [2:0] diag;
	} src_req_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [175:0] m_tdata;
	logic [7:0]   m_tuser;
	logic         m_tlast;

	dsl_byte_stream_tokenizer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	src_req_t src_q[$];
	tok_rec_t expected_tokens[$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int failures = 0;
	int bytes_sent = 0;
	int sources_ended = 0;
	int tokens_checked = 0;

	// Lexer state kept by the predictor.
	lex_mode_t   lx_mode;
	logic [7:0]  la0, la1;
	int          la_cnt;
	logic [19:0] cur_line, tok_line;
	logic [15:0] cur_col, tok_col;
	logic [23:0] cur_off, tok_off;
	logic [63:0] acc;
	logic        got_digit, hexmode, bad_num, is_float;
	logic [15:0] cp_cnt, span_n, text_n;
	logic [4:0]  tkind;

	function automatic logic [15:0] inc16(input logic [15:0] x);
		return (x == 16'hFFFF) ? x : x + 16'd1;
	endfunction

	function automatic logic dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic alph(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic alnm(input logic [7:0] c);
		return alph(c) || dig(c);
	endfunction

	function automatic logic hexd(input logic [7:0] c);
		return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [4:0] single_punct(input logic [7:0] c);
		case (c)
			"[": return P_LBRACK;
			"]": return P_RBRACK;
			"(": return P_LPAREN;
			")": return P_RPAREN;
			"<": return P_LESS;
			">": return P_GREATER;
			",": return P_COMMA;
			";": return P_SEMI;
			":": return P_COLON;
			".": return P_DOT;
			"*": return P_STAR;
			"-": return P_MINUS;
			default: return NO_KIND;
		endcase
	endfunction

	function automatic logic [4:0] sigil_of(input logic [7:0] c);
		case (c)
			"$": return SIG_DOLLAR;
			"@": return SIG_AT;
			"#": return SIG_HASH;
			"^": return SIG_CARET;
			"!": return SIG_BANG;
			"?": return SIG_QUEST;
			"~": return SIG_TILDE;
			default: return NO_KIND;
		endcase
	endfunction

	function automatic void push_record(input logic [4:0] kind, input logic [2:0] diag,
			input logic [19:0] ln, input logic [15:0] col, input logic [23:0] off,
			input logic [15:0] span, input logic [15:0] text, input logic [63:0] val,
			input logic [15:0] cps, input logic last);
		tok_rec_t r;
		r.kind = kind; r.diag = diag; r.line = ln; r.col = col; r.off = off;
		r.span = span; r.text = text; r.value = val; r.cps = cps; r.last = last;
		expected_tokens.push_back(r);
	endfunction

	function automatic void emit_token(input logic [4:0] kind, input logic [2:0] diag,
			input logic [15:0] span, input logic [15:0] text, input logic [63:0] val,
			input logic [15:0] cps);
		push_record(kind, diag, tok_line, tok_col, tok_off, span, text, val, cps, 1'b0);
		lx_mode = M_IDLE;
	endfunction

	function automatic void finish_number();
		if (bad_num)
			emit_token(KIND_ERROR, DIAG_BAD_NUM, span_n, span_n, 64'd0, 16'd0);
		else if (is_float)
			emit_token(KIND_FLOAT, DIAG_NONE, span_n, span_n, 64'd0, 16'd0);
		else
			emit_token(KIND_INT, DIAG_NONE, span_n, span_n, acc, 16'd0);
	endfunction

	// Letters glued to a literal make it bad and swallow the rest of the word.
	function automatic void tail_or_end(input logic [7:0] c1);
		if (alph(c1)) begin
			bad_num = 1'b1;
			lx_mode = M_TAIL;
		end else begin
			finish_number();
		end
	endfunction

	function automatic void exponent_or_end(input logic [7:0] c1);
		if (c1 == "e" || c1 == "E") lx_mode = M_EXPE;
		else tail_or_end(c1);
	endfunction

	// A single dot followed by something other than a dot enters the fraction; with no digit after it the literal is bad.
	function automatic void decimal_next(input logic [7:0] c1, input logic [7:0] c2);
		if (dig(c1) || c1 == "_") lx_mode = M_DEC;
		else if (c1 == "." && c2 != ".") lx_mode = M_DOT;
		else exponent_or_end(c1);
	endfunction

	function automatic void radix_next(input logic [7:0] c1);
		logic more;
		more = hexmode ? hexd(c1) : (c1 == "0" || c1 == "1");
		if (more || c1 == "_") return;
		if (!got_digit) bad_num = 1'b1;
		tail_or_end(c1);
	endfunction

	function automatic void name_next(input logic [7:0] c1, input logic [7:0] c2);
		logic more;
		more = alnm(c1);
		if (lx_mode == M_KEBAB && c1 == "-" && alnm(c2)) more = 1'b1;
		if (lx_mode == M_DOTTED && c1 == "." && alph(c2)) more = 1'b1;
		if (!more) emit_token(tkind, DIAG_NONE, span_n, text_n, 64'd0, 16'd0);
	endfunction

	function automatic void open_token(input logic [19:0] ln, input logic [15:0] col,
			input logic [23:0] off);
		tok_line = ln; tok_col = col; tok_off = off;
		span_n = 16'd1; text_n = 16'd0; acc = 64'd0;
		got_digit = 1'b0; cp_cnt = 16'd0; bad_num = 1'b0; is_float = 1'b0;
	endfunction

	function automatic void start_from_idle(input logic [7:0] c, input logic [7:0] c1,
			input logic [7:0] c2, input logic [19:0] ln, input logic [15:0] col,
			input logic [23:0] off);
		logic [4:0] pair, k;
		pair = NO_KIND;
		if (c == " " || c == "\t" || c == "\r" || c == "\n") return;
		if (c == "/" && c1 == "/") begin
			lx_mode = M_LCOM;
			return;
		end
		if (c == "/" && c1 == "*") begin
			open_token(ln, col, off);
			lx_mode = M_BOPEN;
			return;
		end
		if (c == "-" && c1 == ">") pair = KIND_ARROW;
		else if (c == "=" && c1 == ">") pair = KIND_FATARR;
		else if (c == "*" && c1 == "&") pair = KIND_STARAMP;
		else if (c == "." && c1 == ".") pair = KIND_DOTDOT;
		open_token(ln, col, off);
		if (pair != NO_KIND) begin
			emit_token(pair, DIAG_NONE, 16'd2, 16'd2, 64'd0, 16'd0);
			lx_mode = M_SKIP;
			return;
		end
		k = single_punct(c);
		if (k != NO_KIND) begin
			emit_token(k, DIAG_NONE, 16'd1, 16'd1, 64'd0, 16'd0);
			return;
		end
		k = sigil_of(c);
		if (k != NO_KIND) begin
			tkind = k;
			if (!alph(c1)) emit_token(KIND_ERROR, DIAG_EMPTY_SIGIL, 16'd1, 16'd0, 64'd0, 16'd0);
			else if (c == "@") lx_mode = M_DOTTED;
			else if (c == "!" || c == "~") lx_mode = M_KEBAB;
			else lx_mode = M_ID;
			return;
		end
		if (dig(c)) begin
			if (c == "0" && (c1 == "x" || c1 == "X")) begin
				hexmode = 1'b1;
				lx_mode = M_PFX;
			end else if (c == "0" && (c1 == "b" || c1 == "B")) begin
				hexmode = 1'b0;
				lx_mode = M_PFX;
			end else begin
				acc = 64'(c - "0");
				decimal_next(c1, c2);
			end
			return;
		end
		if (alph(c)) begin
			tkind = KIND_IDENT;
			text_n = 16'd1;
			lx_mode = M_ID;
			name_next(c1, c2);
			return;
		end
		if (c >= 8'h80) begin
			cp_cnt = ((c & 8'hC0) != 8'h80) ? 16'd1 : 16'd0;
			if (c1 >= 8'h80) lx_mode = M_JUNK;
			else emit_token(KIND_DIAG, DIAG_BAD_CHAR, 16'd1, 16'd1, 64'd0, cp_cnt);
			return;
		end
		emit_token(KIND_DIAG, DIAG_BAD_CHAR, 16'd1, 16'd1, 64'd0, 16'd0);
	endfunction

	// Consumes byte c, with c1 and c2 as its lookahead.
	function automatic void consume_byte(input logic [7:0] c, input logic [7:0] c1,
			input logic [7:0] c2);
		logic [19:0] ln;
		logic [15:0] col;
		logic [23:0] off;
		lex_mode_t   m;
		logic [63:0] d;
		ln = cur_line; col = cur_col; off = cur_off; m = lx_mode;
		if (cur_off != 24'hFFFFFF) cur_off = cur_off + 24'd1;
		if (c == "\n") begin
			if (cur_line != 20'hFFFFF) cur_line = cur_line + 20'd1;
			cur_col = 16'd1;
		end else begin
			cur_col = inc16(cur_col);
		end
		if (m >= M_ID) span_n = inc16(span_n);
		case (m)
			M_IDLE: start_from_idle(c, c1, c2, ln, col, off);
			M_SKIP, M_BCLOSE: lx_mode = M_IDLE;
			M_LCOM: if (c == "\n") lx_mode = M_IDLE;
			M_BOPEN: lx_mode = M_BCOM;
			M_BCOM: if (c == "*" && c1 == "/") lx_mode = M_BCLOSE;
			M_ID, M_KEBAB, M_DOTTED: begin
				text_n = inc16(text_n);
				name_next(c1, c2);
			end
			M_JUNK: begin
				if ((c & 8'hC0) != 8'h80) cp_cnt = inc16(cp_cnt);
				if (c1 < 8'h80) emit_token(KIND_DIAG, DIAG_BAD_CHAR, span_n, span_n, 64'd0, cp_cnt);
			end
			M_PFX: begin
				lx_mode = hexmode ? M_HEX : M_BIN;
				radix_next(c1);
			end
			M_HEX, M_BIN: begin
				if (c != "_") begin
					if (dig(c)) d = 64'(c - "0");
					else d = 64'(c | 8'h20) - 64'("a") + 64'd10;
					acc = acc * (hexmode ? 64'd16 : 64'd2) + d;
					got_digit = 1'b1;
				end
				radix_next(c1);
			end
			M_DEC: begin
				if (dig(c)) acc = acc * 64'd10 + 64'(c - "0");
				decimal_next(c1, c2);
			end
			M_DOT: begin
				if (dig(c1)) begin
					is_float = 1'b1;
					lx_mode = M_FRAC;
				end else begin
					bad_num = 1'b1;
					exponent_or_end(c1);
				end
			end
			M_FRAC: if (!(dig(c1) || c1 == "_")) exponent_or_end(c1);
			M_EXPE: begin
				if (dig(c1) || ((c1 == "+" || c1 == "-") && dig(c2))) begin
					is_float = 1'b1;
					lx_mode = (c1 == "+" || c1 == "-") ? M_EXPSIGN : M_EXPDIG;
				end else begin
					bad_num = 1'b1;
					if (alnm(c1)) lx_mode = M_TAIL;
					else finish_number();
				end
			end
			M_EXPSIGN: lx_mode = M_EXPDIG;
			M_EXPDIG: if (!dig(c1)) tail_or_end(c1);
			M_TAIL: if (!alnm(c1)) finish_number();
			default: lx_mode = M_IDLE;
		endcase
	endfunction

	function automatic void clear_lexer();
		lx_mode = M_IDLE;
		la0 = 8'd0; la1 = 8'd0; la_cnt = 0;
		cur_line = 20'd1; cur_col = 16'd1; cur_off = 24'd0;
		open_token(20'd1, 16'd1, 24'd0);
		span_n = 16'd0; tkind = NO_KIND; hexmode = 1'b0;
	endfunction

	// Works out the token records released by one accepted source request.
	function automatic void tokenize_request(input logic [7:0] b, input logic eos);
		if (!eos) begin
			if (la_cnt == 0) begin
				la0 = b; la_cnt = 1;
			end else if (la_cnt == 1) begin
				la1 = b; la_cnt = 2;
			end else begin
				consume_byte(la0, la1, b);
				la0 = la1; la1 = b;
			end
			return;
		end
		if (la_cnt >= 2) begin
			consume_byte(la0, la1, 8'd0);
			la0 = la1; la_cnt = 1;
		end
		if (la_cnt == 1) consume_byte(la0, 8'd0, 8'd0);
		if (lx_mode == M_BOPEN || lx_mode == M_BCOM)
			emit_token(KIND_DIAG, DIAG_UNCLOSED, 16'd2, 16'd2, 64'd0, 16'd0);
		push_record(KIND_END, DIAG_NONE, cur_line, cur_col, cur_off, 16'd0, 16'd0, 64'd0,
			16'd0, 1'b1);
		clear_lexer();
	endfunction

	initial clear_lexer();

	// Directed source text: empty source, empty sigil, bad hex prefix, unclosed
	// comment, zero byte, non-ASCII run, every two-byte punctuator.
	localparam int DIR_ROWS = 24;
	src_req_t dir_rows [0:DIR_ROWS-1] = '{
		'{8'd0,  1'b1, 1'b1, KIND_END,     DIAG_NONE},
		'{"$",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{" ",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{"x",   1'b0, 1'b1, KIND_ERROR,   DIAG_EMPTY_SIGIL},
		'{" ",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{"0",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{"x",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{";",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{"\n",  1'b0, 1'b1, KIND_ERROR,   DIAG_BAD_NUM},
		'{"/",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{"*",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{8'hA5, 1'b1, 1'b1, KIND_DIAG,    DIAG_UNCLOSED},
		'{8'h00, 1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{8'hFF, 1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{8'hC3, 1'b0, 1'b1, KIND_DIAG,    DIAG_BAD_CHAR},
		'{"-",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{">",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{".",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{".",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{"*",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{"&",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{"=",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{">",   1'b0, 1'b0, NO_KIND,      DIAG_NONE},
		'{8'h5A, 1'b1, 1'b1, KIND_FATARR,  DIAG_NONE}
	};

	// Sender: a new request is offered only once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'd0;
			s_tlast  <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (src_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= src_q[0].b;
				s_tlast  <= src_q[0].eos;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// The sender does not pop: the monitor pops the queue head when the request is taken,
	// so the head matches what is on the bus. The block below has an empty body.
	src_req_t on_bus[$];
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready) && src_q.size() != 0 && 1'b0) begin
		end
	end

	// Receiver: random stalls, plus a long hold-off on request from the main process.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
		end else if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= 80;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			failures++;
		end
	endfunction

	// Monitor: predicts on each accepted request and checks each accepted record.
	always @(posedge clk) begin
		int       n0;
		src_req_t req;
		tok_rec_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				req = src_q.pop_front();
				n0 = expected_tokens.size();
				tokenize_request(s_tdata, s_tlast);
				if (s_tlast) sources_ended++;
				else bytes_sent++;
				if (req.typed) begin
					if (expected_tokens.size() == n0) begin
						$error("kind mismatch: expected %0d, got no record", req.kind);
						failures++;
					end else begin
						check_field("token_kind", req.kind, expected_tokens[n0].kind);
						check_field("diag_code", req.diag, expected_tokens[n0].diag);
					end
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected record: kind %0d", m_tuser[4:0]);
					failures++;
				end else begin
					e = expected_tokens.pop_front();
					tokens_checked++;
					check_field("token_kind", e.kind, m_tuser[4:0]);
					check_field("diag_code", e.diag, m_tuser[7:5]);
					check_field("start_line", e.line, m_tdata[19:0]);
					check_field("start_column", e.col, m_tdata[35:20]);
					check_field("start_offset", e.off, m_tdata[59:36]);
					check_field("span_length", e.span, m_tdata[75:60]);
					check_field("text_length", e.text, m_tdata[91:76]);
					check_field("int_value", e.value, m_tdata[155:92]);
					check_field("codepoint_count", e.cps, m_tdata[171:156]);
					check_field("last", e.last, m_tlast);
				end
			end
		end
	end

	function automatic void add_byte(input logic [7:0] b);
		src_req_t r;
		r = '{b, 1'b0, 1'b0, NO_KIND, DIAG_NONE};
		src_q.push_back(r);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	// Appends one random lexical fragment and returns its byte count.
	function automatic int add_fragment();
		string letters, alnum, hexs;
		int n, before_q;
		letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
		alnum = "abcdefxyzXYZ_0123456789";
		hexs = "0123456789abcdefABCDEF_";
		before_q = src_q.size();
		case ($urandom_range(13))
			0: begin
				add_byte(pick(letters));
				n = $urandom_range(6);
				repeat (n) add_byte(pick(alnum));
			end
			1: begin
				add_byte(pick("123456789"));
				n = ($urandom_range(4) == 0) ? $urandom_range(18, 24) : $urandom_range(4);
				repeat (n) add_byte(pick("0123456789_"));
			end
			2: begin
				add_text($urandom_range(1) ? "0x" : "0X");
				n = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 18);
				repeat (n) add_byte(pick(hexs));
			end
			3: begin
				add_text($urandom_range(1) ? "0b" : "0B");
				n = ($urandom_range(6) == 0) ? $urandom_range(64, 70) : $urandom_range(0, 10);
				repeat (n) add_byte(pick("01_"));
			end
			4: begin
				add_byte(pick("0123456789"));
				add_byte(".");
				if ($urandom_range(4) != 0) repeat ($urandom_range(1, 3)) add_byte(pick("0123456789"));
				if ($urandom_range(1)) begin
					add_byte(pick("eE"));
					if ($urandom_range(1)) add_byte(pick("+-"));
					if ($urandom_range(3) != 0) repeat ($urandom_range(1, 2)) add_byte(pick("0123456789"));
				end
			end
			5: begin
				add_byte(pick("$@#^!?~"));
				if ($urandom_range(4) != 0) begin
					add_byte(pick(letters));
					repeat ($urandom_range(3)) add_byte(pick(alnum));
					if ($urandom_range(1)) begin
						add_byte(pick(".-"));
						add_byte(pick(letters));
						repeat ($urandom_range(2)) add_byte(pick(alnum));
					end
				end
			end
			6: begin
				if ($urandom_range(1)) add_byte(pick("[]()<>,;:.*-"));
				else case ($urandom_range(3))
					0: add_text("->");
					1: add_text("=>");
					2: add_text("*&");
					default: add_text("..");
				endcase
			end
			7: repeat ($urandom_range(1, 3)) add_byte(pick(" \t\r\n"));
			8: begin
				add_text("//");
				repeat ($urandom_range(4)) add_byte(pick("ab *;/\t"));
				add_byte("\n");
			end
			9: begin
				add_text("/*");
				repeat ($urandom_range(5)) add_byte(pick("ab*\n /"));
				add_text("*/");
			end
			10: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(8'h80, 8'hFF)));
			11: add_byte(8'($urandom_range(255)));
			12: begin
				add_byte(pick("0123456789"));
				add_byte(pick(letters));
				add_byte(pick(alnum));
			end
			default: add_byte(pick("=/%&'\"+"));
		endcase
		if ($urandom_range(3) != 0) add_byte(pick(" \n"));
		return src_q.size() - before_q;
	endfunction

	function automatic void add_end_of_source();
		src_req_t r;
		r = '{8'($urandom_range(255)), 1'b1, 1'b0, NO_KIND, DIAG_NONE};
		src_q.push_back(r);
	endfunction

	task automatic wait_drained();
		while (src_q.size() != 0 || s_tvalid) @(negedge clk);
		while (expected_tokens.size() != 0) @(negedge clk);
	endtask

	task automatic random_phase(input int idle_pct, input int stall, input int items,
			input bit hold);
		int added;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		added = 0;
		if (hold) begin
			// Enough text up front that the block fills up during the hold-off.
			while (added < 16) added += add_fragment();
			hold_req++;
		end
		while (added < items) added += add_fragment();
		add_end_of_source();
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++) src_q.push_back(dir_rows[i]);
		wait_drained();
		random_phase(0, 0, 40, 1'b1);
		random_phase(46, 0, 40, 1'b0);
		random_phase(0, 46, 40, 1'b0);
		random_phase(37, 37, 40, 1'b0);
		random_phase(0, 0, 20, 1'b0);
		repeat (20) @(posedge clk);
		$display("Sent %0d source bytes over %0d sources; checked %0d token records.",
			bytes_sent, sources_ended, tokens_checked);
		if (failures == 0) begin
			$display("tb_dsl_byte_stream_tokenizer passed");
		end else begin
			$display("tb_dsl_byte_stream_tokenizer failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_dsl_byte_stream_tokenizer failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/dbst_pkg.sv
rtl/core/dbst_front.sv
rtl/core/dbst_fifo.sv
rtl/core/dbst_back.sv
rtl/core/dsl_byte_stream_tokenizer.sv
test/tb_dsl_byte_stream_tokenizer.sv
